>>> hw/rtl/lnr_pkg.sv
// Shared types and constants for the row layer-normalisation block.
package lnr_pkg;

    localparam int SMP_W   = 16;   // Q8.8 sample, gain and offset width
    localparam int CNT_W   = 7;    // row fill count width
    localparam int TOT_W   = 22;   // running sum of samples
    localparam int DIV_W   = 42;   // shared divider operand width
    localparam int SQ_W    = 41;   // sum of squared deviations
    localparam int QDEPTH  = 4;    // front-to-back queue depth
    localparam int QPTR_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EPS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_OFFSET = 2'd2;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic signed [SMP_W-1:0] gain;
        logic signed [SMP_W-1:0] offset;
        logic                    row_end;
        logic                    drop;
    } lnr_item_t;

    typedef struct packed {
        logic [SMP_W-1:0] eps;
        logic             use_gain;
        logic             use_offset;
    } lnr_cfg_t;

endpackage

>>> hw/rtl/lnr_front.sv
// Input front end: accepts items and marks those beyond the row capacity.
module lnr_front #(
    parameter int ROW_CAPACITY = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [47:0]             s_tdata,
    input  logic                    s_tlast,
    input  logic                    q_full,
    output logic                    q_push,
    output lnr_pkg::lnr_item_t      q_item
);

    logic [lnr_pkg::CNT_W-1:0] fcnt_reg;
    logic                      at_cap;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign at_cap   = (fcnt_reg == lnr_pkg::CNT_W'(ROW_CAPACITY));

    always_comb
    begin
        q_item.sample  = s_tdata[15:0];
        q_item.gain    = s_tdata[31:16];
        q_item.offset  = s_tdata[47:32];
        q_item.row_end = s_tlast;
        q_item.drop    = at_cap;
    end

    // Mirror of the row fill count, so that drops are decided on entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
        end
        else if (q_push)
        begin
            if (s_tlast)
                fcnt_reg <= '0;
            else if (!at_cap)
                fcnt_reg <= fcnt_reg + 1'b1;
        end
    end

endmodule

>>> hw/rtl/lnr_fifo.sv
// Short queue between the front end and the normalisation engine.
module lnr_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lnr_pkg::lnr_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output lnr_pkg::lnr_item_t pop_item
);

    lnr_pkg::lnr_item_t              slot_reg [lnr_pkg::QDEPTH];
    logic [lnr_pkg::QPTR_W-1:0]      wr_reg;
    logic [lnr_pkg::QPTR_W-1:0]      rd_reg;
    logic [lnr_pkg::QPTR_W:0]        used_reg;

    assign full      = (used_reg == (lnr_pkg::QPTR_W+1)'(lnr_pkg::QDEPTH));
    assign not_empty = (used_reg != '0);
    assign pop_item  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                used_reg <= used_reg + 1'b1;
            else if (pop && !push)
                used_reg <= used_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/lnr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lnr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lnr_pkg::DIV_W-1:0]   dividend,
    input  logic [lnr_pkg::DIV_W-1:0]   divisor,
    output logic                        done,
    output logic [lnr_pkg::DIV_W-1:0]   quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [5:0]                    step_reg;
    logic [lnr_pkg::DIV_W-1:0]     q_reg;
    logic [lnr_pkg::DIV_W-1:0]     d_reg;
    logic [lnr_pkg::DIV_W:0]       r_reg;
    logic [lnr_pkg::DIV_W:0]       r_sh;
    logic                          fits;

    assign r_sh     = {r_reg[lnr_pkg::DIV_W-1:0], q_reg[lnr_pkg::DIV_W-1]};
    assign fits     = (r_sh >= {1'b0, d_reg});
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 6'(lnr_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                r_reg <= r_sh - {1'b0, d_reg};
                q_reg <= {q_reg[lnr_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[lnr_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

`ifndef SYNTH
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a run");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
`endif

endmodule

>>> hw/rtl/lnr_back.sv
// Normalisation engine: row store, statistics, reciprocal root and output pass.
module lnr_back #(
    parameter int ROW_CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lnr_pkg::lnr_cfg_t  cfg,
    input  logic               q_not_empty,
    input  lnr_pkg::lnr_item_t q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    localparam int AW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int MW = 3 * lnr_pkg::SMP_W;

    typedef enum logic [4:0] {
        S_LOAD, S_MEAN_GO, S_MEAN_WT, S_VRD, S_VSQ, S_VACC, S_VDIV_GO, S_VDIV_WT,
        S_RDIV_GO, S_RDIV_WT, S_SQRT, S_SAT, S_ORD, S_OMUL, S_OGAIN, S_OFIN, S_OWR
    } state_t;

    state_t                        state_reg;
    logic [lnr_pkg::CNT_W-1:0]     cnt_reg;
    logic [lnr_pkg::CNT_W-1:0]     idx_reg;
    logic signed [lnr_pkg::TOT_W-1:0] total_reg;
    logic                          ovf_reg;
    logic signed [16:0]            mean_reg;
    logic [lnr_pkg::SQ_W-1:0]      sq_reg;
    logic [33:0]                   dsq_reg;
    logic [lnr_pkg::DIV_W-1:0]     rad_reg;
    logic [20:0]                   root_reg;
    logic [24:0]                   rem_reg;
    logic [4:0]                    step_reg;
    logic [15:0]                   rstd_reg;
    logic signed [33:0]            p1_reg;
    logic signed [51:0]            p2_reg;
    logic signed [15:0]            g_reg;
    logic signed [15:0]            b_reg;
    logic signed [15:0]            y_reg;
    logic                          m_tvalid_reg;
    logic [15:0]                   m_tdata_reg;
    logic                          m_tlast_reg;
    logic                          m_tuser_reg;

    logic [MW-1:0]                 mem [ROW_CAPACITY];
    logic [MW-1:0]                 rd_reg;

    logic                          div_start;
    logic [lnr_pkg::DIV_W-1:0]     div_a;
    logic [lnr_pkg::DIV_W-1:0]     div_b;
    logic                          div_done;
    logic [lnr_pkg::DIV_W-1:0]     div_q;

    logic signed [15:0]            rd_x;
    logic signed [15:0]            rd_g;
    logic signed [15:0]            rd_b;
    logic signed [16:0]            dv_w;
    logic signed [33:0]            dv_x;
    logic signed [16:0]            rstd_s;
    logic signed [33:0]            prod1_w;
    logic signed [49:0]            prod2_w;
    logic signed [51:0]            off_w;
    logic signed [51:0]            rnd_w;
    logic signed [51:0]            sum_w;
    logic signed [51:0]            y_w;
    logic [lnr_pkg::DIV_W-1:0]     den_w;
    logic [24:0]                   rem_n;
    logic [24:0]                   trial_w;
    logic [lnr_pkg::TOT_W-1:0]     tot_mag;
    logic                          last_idx;
    logic                          out_load;

    assign q_pop = (state_reg == S_LOAD) && q_not_empty;

    assign rd_x = rd_reg[15:0];
    assign rd_g = rd_reg[31:16];
    assign rd_b = rd_reg[47:32];

    always_comb
    begin
        dv_w     = 17'(rd_x) - mean_reg;
        dv_x     = 34'(dv_w);
        rstd_s   = $signed({1'b0, rstd_reg});
        prod1_w  = dv_w * rstd_s;
        prod2_w  = p1_reg * g_reg;
        if (cfg.use_offset)
            off_w = cfg.use_gain ? (52'(b_reg) <<< 20) : (52'(b_reg) <<< 12);
        else
            off_w = '0;
        rnd_w    = cfg.use_gain ? (52'sd1 <<< 19) : (52'sd1 <<< 11);
        sum_w    = p2_reg + off_w + rnd_w;
        y_w      = cfg.use_gain ? (sum_w >>> 20) : (sum_w >>> 12);
        den_w    = div_q + lnr_pkg::DIV_W'(cfg.eps);
        rem_n    = {rem_reg[22:0], rad_reg[lnr_pkg::DIV_W-1 -: 2]};
        trial_w  = {2'b00, root_reg, 2'b01};
        tot_mag  = total_reg[lnr_pkg::TOT_W-1] ? lnr_pkg::TOT_W'(-total_reg)
                                               : lnr_pkg::TOT_W'(total_reg);
        last_idx = (idx_reg == cnt_reg - 1'b1);
        out_load = (state_reg == S_OWR) && (!m_tvalid_reg || m_tready);
    end

    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = lnr_pkg::DIV_W'(cnt_reg);
        case (state_reg)
            S_MEAN_GO:
            begin
                div_start = 1'b1;
                div_a     = lnr_pkg::DIV_W'(tot_mag);
            end
            S_VDIV_GO:
            begin
                div_start = 1'b1;
                div_a     = lnr_pkg::DIV_W'(sq_reg);
            end
            S_RDIV_GO:
            begin
                div_start = 1'b1;
                div_a     = lnr_pkg::DIV_W'(1) << 40;
                div_b     = rad_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    lnr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Row store: one write port from the queue, one registered read port.
    always_ff @(posedge clk)
    begin
        if (q_pop && !q_item.drop)
            mem[cnt_reg[AW-1:0]] <= {q_item.offset, q_item.gain, q_item.sample};
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            mean_reg     <= '0;
            sq_reg       <= '0;
            dsq_reg      <= '0;
            rad_reg      <= '0;
            root_reg     <= '0;
            rem_reg      <= '0;
            step_reg     <= '0;
            rstd_reg     <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            g_reg        <= '0;
            b_reg        <= '0;
            y_reg        <= '0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (q_not_empty)
                    begin
                        if (q_item.drop)
                            ovf_reg <= 1'b1;
                        else
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            total_reg <= total_reg + lnr_pkg::TOT_W'(q_item.sample);
                        end
                        if (q_item.row_end)
                            state_reg <= S_MEAN_GO;
                    end
                end
                S_MEAN_GO:
                    state_reg <= S_MEAN_WT;
                S_MEAN_WT:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= total_reg[lnr_pkg::TOT_W-1] ? -$signed(div_q[16:0])
                                                                 : $signed(div_q[16:0]);
                        sq_reg    <= '0;
                        idx_reg   <= '0;
                        state_reg <= S_VRD;
                    end
                end
                S_VRD:
                    state_reg <= S_VSQ;
                S_VSQ:
                begin
                    dsq_reg   <= $unsigned(dv_x * dv_x);
                    state_reg <= S_VACC;
                end
                S_VACC:
                begin
                    sq_reg <= sq_reg + lnr_pkg::SQ_W'(dsq_reg);
                    if (last_idx)
                        state_reg <= S_VDIV_GO;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_VRD;
                    end
                end
                S_VDIV_GO:
                    state_reg <= S_VDIV_WT;
                S_VDIV_WT:
                begin
                    if (div_done)
                    begin
                        rad_reg <= den_w;
                        idx_reg <= '0;
                        if (den_w == '0)
                        begin
                            rstd_reg  <= 16'hFFFF;
                            state_reg <= S_ORD;
                        end
                        else
                            state_reg <= S_RDIV_GO;
                    end
                end
                S_RDIV_GO:
                    state_reg <= S_RDIV_WT;
                S_RDIV_WT:
                begin
                    if (div_done)
                    begin
                        rad_reg   <= div_q;
                        root_reg  <= '0;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (rem_n >= trial_w)
                    begin
                        rem_reg  <= rem_n - trial_w;
                        root_reg <= {root_reg[19:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_n;
                        root_reg <= {root_reg[19:0], 1'b0};
                    end
                    rad_reg  <= rad_reg << 2;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd20)
                        state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    rstd_reg  <= (root_reg > 21'd65535) ? 16'hFFFF : root_reg[15:0];
                    state_reg <= S_ORD;
                end
                S_ORD:
                    state_reg <= S_OMUL;
                S_OMUL:
                begin
                    p1_reg    <= prod1_w;
                    g_reg     <= rd_g;
                    b_reg     <= rd_b;
                    state_reg <= S_OGAIN;
                end
                S_OGAIN:
                begin
                    p2_reg    <= cfg.use_gain ? 52'(prod2_w) : 52'(p1_reg);
                    state_reg <= S_OFIN;
                end
                S_OFIN:
                begin
                    if (y_w > 52'sd32767)
                        y_reg <= 16'sh7FFF;
                    else if (y_w < -52'sd32768)
                        y_reg <= -16'sh8000;
                    else
                        y_reg <= y_w[15:0];
                    state_reg <= S_OWR;
                end
                S_OWR:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= y_reg;
                        m_tlast_reg  <= last_idx;
                        m_tuser_reg  <= ovf_reg;
                        if (last_idx)
                        begin
                            cnt_reg   <= '0;
                            total_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lnr_pkg::CNT_W'(ROW_CAPACITY))
        else $error("row fill count beyond capacity");
    a_drop_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.drop && !q_item.row_end) |=> $stable(cnt_reg))
        else $error("dropped item changed the fill count");
    a_pop_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_LOAD))
        else $error("queue popped outside the load phase");
`endif

endmodule

>>> hw/rtl/layer_norm_row_top.sv
// Top level of the row layer-normalisation block with its register port.
// Results of a row appear only after its last item has been loaded.
// Rows go through one at a time: loading takes each item from the queue as it comes; the row
// then needs the mean division in the shared divider, the variance pass and division, unless
// the denominator is zero the reciprocal division, root and saturation, and the output pass.
// Reset (rst_n, asynchronous, active low) empties the queue and row state and sets the
// registers to eps = 1, use_gain = 1, use_offset = 1; the row store itself is not cleared.
module layer_norm_row_top #(
    parameter int ROW_CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // sample [15:0], gain [31:16], offset [47:32]
    input  logic        s_tlast,    // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // normalized [15:0]
    output logic        m_tlast,    // run_end
    output logic        m_tuser,    // overflowed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lnr_pkg::lnr_cfg_t  cfg_reg;
    lnr_pkg::lnr_item_t push_item;
    lnr_pkg::lnr_item_t pop_item;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;

    // Register writes are always taken at once; an unknown index is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eps        <= 16'd1;
            cfg_reg.use_gain   <= 1'b1;
            cfg_reg.use_offset <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lnr_pkg::CFG_EPS:        cfg_reg.eps        <= cfg_data;
                lnr_pkg::CFG_USE_GAIN:   cfg_reg.use_gain   <= cfg_data[0];
                lnr_pkg::CFG_USE_OFFSET: cfg_reg.use_offset <= cfg_data[0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // The front end decides drops on entry, so the engine never needs to look ahead.
    lnr_front #(
        .ROW_CAPACITY (ROW_CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // The queue lets the next row's first items arrive while the engine finishes a row.
    lnr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    lnr_back #(
        .ROW_CAPACITY (ROW_CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

>>> dv/tb_layer_norm_row_top.sv
// Self-checking testbench for the row layer-normalisation block.
module tb_layer_norm_row_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // One expected result: normalised value, end-of-row mark and overflow mark.
    typedef struct {
        logic [15:0] norm;
        logic        last;
        logic        ovf;
    } norm_result_t;

    norm_result_t pending_norms[$];

    // The predictor's own copy of the row state and the registers.
    logic signed [15:0] row_x[CAP];
    logic signed [15:0] row_g[CAP];
    logic signed [15:0] row_b[CAP];
    int unsigned row_fill;
    longint      row_sum;
    bit          row_ovf;
    logic [15:0] eps_reg;
    bit          gain_on;
    bit          offset_on;

    int     error_count;
    int     items_sent;
    int     results_seen;
    int     rows_done;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_stall_pct;

    layer_norm_row_top #(.ROW_CAPACITY(CAP)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and watchdog.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles.", cycle_count);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // floor(sqrt(v)) by restoring steps over 42 bits.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        root = 0;
        rem = 0;
        for (int i = 20; i >= 0; i--)
        begin
            rem = (rem << 2) | ((v >> (2 * i)) & 3);
            trial = (root << 2) | 1;
            root = root << 1;
            if (rem >= trial)
            begin
                rem -= trial;
                root |= 1;
            end
        end
        return root;
    endfunction

    // Takes one item into the predicted row; at the row's end, queues its results.
    task automatic predict_row_item(logic signed [15:0] x, logic signed [15:0] g,
                                    logic signed [15:0] b, bit last);
        longint mean;
        longint dv;
        longint p;
        longint y;
        longint unsigned sq;
        longint unsigned den;
        longint unsigned rstd;
        int unsigned s;
        norm_result_t r;
        if (row_fill < CAP)
        begin
            row_x[row_fill] = x;
            row_g[row_fill] = g;
            row_b[row_fill] = b;
            row_fill++;
            row_sum += x;
        end
        else
            row_ovf = 1;
        if (!last)
            return;
        if (row_fill > 0)
        begin
            mean = row_sum / longint'(row_fill);   // truncates toward zero
            sq = 0;
            for (int i = 0; i < row_fill; i++)
            begin
                dv = longint'(row_x[i]) - mean;
                sq += longint'(dv * dv);
            end
            den = sq / row_fill + eps_reg;
            if (den == 0)
                rstd = 65535;
            else
            begin
                rstd = root_floor((64'd1 << 40) / den);
                if (rstd > 65535)
                    rstd = 65535;
            end
            for (int i = 0; i < row_fill; i++)
            begin
                dv = longint'(row_x[i]) - mean;
                p = dv * longint'(rstd);
                s = 12;
                if (gain_on)
                begin
                    p = p * longint'(row_g[i]);
                    s = 20;
                end
                if (offset_on)
                    p += longint'(row_b[i]) <<< s;
                p += longint'(1) <<< (s - 1);
                y = p >>> s;                        // arithmetic shift floors
                if (y > 32767)
                    y = 32767;
                if (y < -32768)
                    y = -32768;
                r.norm = y[15:0];
                r.last = (i == row_fill - 1);
                r.ovf  = row_ovf;
                pending_norms.push_back(r);
            end
        end
        row_fill = 0;
        row_sum = 0;
        row_ovf = 0;
    endtask

    // Sends one item, idling beforehand at the current rate; valid stays up until the
    // next idle cycle or the next item, so back-to-back items need no gap.
    task automatic send_row_item(logic [15:0] x, logic [15:0] g, logic [15:0] b, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, x};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_row_item(x, g, b, last);
        items_sent++;
    endtask

    // Lets every expected result drain, then the block settle, before a register write.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_norms.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == lnr_pkg::CFG_EPS)
            eps_reg = val;
        else if (idx == lnr_pkg::CFG_USE_GAIN)
            gain_on = val[0];
        else if (idx == lnr_pkg::CFG_USE_OFFSET)
            offset_on = val[0];
    endtask

    // Result side: random stalls and a field-by-field comparison.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_norms.size() == 0)
                begin
                    $error("Unexpected result: normalized %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    automatic norm_result_t e = pending_norms.pop_front();
                    results_seen++;
                    if (m_tlast)
                        rows_done++;
                    if (m_tdata !== e.norm)
                    begin
                        $error("normalized: expected %h, got %h", e.norm, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("run_end: expected %b, got %b", e.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== e.ovf)
                    begin
                        $error("overflowed: expected %b, got %b", e.ovf, m_tuser);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Directed table: sample, gain, offset, row_end, and where it is obvious the result.
    typedef struct {
        logic [15:0] x;
        logic [15:0] g;
        logic [15:0] b;
        bit          last;
        bit          known;
        logic [15:0] norm;
    } directed_row_t;

    directed_row_t directed_rows[] = '{
        // A lone element has zero deviation, so the result is its offset.
        '{16'h7FFF, 16'h7FFF, 16'h1234, 1, 1, 16'h1234},
        '{16'h8000, 16'h8000, 16'h8000, 1, 1, 16'h8000},
        // Two extremes: large scaled values that saturate both ways.
        '{16'h8000, 16'h7FFF, 16'h7FFF, 0, 0, 16'h0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 16'h0},
        '{16'h7FFF, 16'h8000, 16'h8000, 0, 0, 16'h0},
        '{16'h8000, 16'h8000, 16'h8000, 1, 0, 16'h0},
        // A small mixed row with negative sum, to exercise truncation of the mean.
        '{16'hFFFF, 16'h0100, 16'h0000, 0, 0, 16'h0},
        '{16'hFFFE, 16'h0100, 16'h0000, 0, 0, 16'h0},
        '{16'h0002, 16'h0100, 16'hFFFF, 1, 0, 16'h0},
        // Equal values give zero variance: the result is the offset.
        '{16'h0500, 16'h5555, 16'hAAAA, 0, 1, 16'hAAAA},
        '{16'h0500, 16'hAAAA, 16'h5555, 1, 1, 16'h5555}
    };

    initial
    begin
        int n;
        int len;
        bit last;
        logic [15:0] x;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        rows_done = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        row_fill = 0;
        row_sum = 0;
        row_ovf = 0;
        eps_reg = 16'd1;
        gain_on = 1;
        offset_on = 1;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lnr_pkg::CFG_EPS;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset register values.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
            begin
                send_row_item(directed_rows[i].x, directed_rows[i].g,
                              directed_rows[i].b, directed_rows[i].last);
                if (directed_rows[i].last &&
                    pending_norms[pending_norms.size()-1].norm !== directed_rows[i].norm)
                begin
                    $error("table: expected %h, predicted %h", directed_rows[i].norm,
                           pending_norms[pending_norms.size()-1].norm);
                    error_count++;
                end
            end
            else
                send_row_item(directed_rows[i].x, directed_rows[i].g,
                              directed_rows[i].b, directed_rows[i].last);
        end
        wait_drained();

        // Zero epsilon with a flat row: the denominator is zero and rstd saturates.
        write_reg(lnr_pkg::CFG_EPS, 16'd0);
        write_reg(lnr_pkg::CFG_USE_GAIN, 16'd0);
        write_reg(lnr_pkg::CFG_USE_OFFSET, 16'd0);
        send_row_item(16'h0100, 16'h0, 16'h0, 0);
        send_row_item(16'h0100, 16'h0, 16'h0, 1);
        send_row_item(16'h0000, 16'h0, 16'h0, 0);
        send_row_item(16'h0001, 16'h0, 16'h0, 1);
        wait_drained();
        write_reg(lnr_pkg::CFG_EPS, 16'hFFFF);
        write_reg(lnr_pkg::CFG_USE_GAIN, 16'hFFFE);     // upper bits ignored: gain off
        write_reg(lnr_pkg::CFG_USE_OFFSET, 16'd1);
        // Overflowing row: capacity plus three, the last dropped item ending the row.
        for (int i = 0; i < CAP + 3; i++)
            send_row_item(16'($urandom), 16'($urandom), 16'($urandom), i == CAP + 2);
        wait_drained();

        // Random phases, each with its own registers and idling pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            write_reg(lnr_pkg::CFG_EPS, (phase == 0) ? 16'd1
                      : 16'($urandom_range(0, 65535) >> $urandom_range(15)));
            write_reg(lnr_pkg::CFG_USE_GAIN, 16'($urandom));
            write_reg(lnr_pkg::CFG_USE_OFFSET, 16'($urandom));
            n = 0;
            while (n < 45)
            begin
                // Mostly short rows; now and then a near-full, full or overlong one.
                len = ($urandom_range(19) == 0) ? $urandom_range(CAP - 2, CAP + 2)
                                                : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    last = (i == len - 1);
                    x = ($urandom_range(3) == 0) ? 16'($urandom)
                                                 : 16'($signed($urandom_range(0, 4095)) - 2048);
                    send_row_item(x, 16'($urandom), 16'($urandom), last);
                    n++;
                end
            end
            wait_drained();
        end

        $display("Sent %0d items in %0d-cycle run; checked %0d results over %0d rows.",
                 items_sent, cycle_count, results_seen, rows_done);
        $display("Covered extremes, zero variance, zero denominator, overflowing rows, all settings.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
